// ===== rtl/nmea_sentence_framer_defines.svh =====
// ----------------------------------------------------------------------------
// nmea sentence framer assertion macros
// shared property forms for the framer rtl, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_DEFINES_SVH

// same-cycle implication
`define NSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// shared constants, field widths and command codes for the sentence framer
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int SLOT_BYTES_DEF = 128;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int OFF_W  = 7;
    localparam int CNT_W  = 3;
    localparam int HEAD_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX      = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

endpackage

`default_nettype wire

// ===== rtl/nsf_ram.sv =====
// ----------------------------------------------------------------------------
// nsf_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nmea_sentence_framer.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// frames serial sentences into a ring of slots held in one byte ram, with
// commands to read a byte of the oldest sentence and to release it
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | sink      | in_valid / in_ready | cmd, rx_byte, read_offset
//  out     | source    | out_valid/out_ready | sentence_done, pending_count,
//          |           |                     | head_length, read_data
//
//  one beat per cycle in while in_ready is high; a result passes through the
//  registered read of the byte ram and then the output register
//  in_ready falls only when both the ram read stage and output register hold
//  beats and out_ready is low
//  reset clears the ring pointers, framing flags and stage valid flags only; the
//  byte ram and the length table are never cleared, and no clearing pass runs after reset
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer #(
    parameter int SLOTS      = nsf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = nsf_pkg::SLOT_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [nsf_pkg::CMD_W-1:0]   cmd,
    input  wire logic [nsf_pkg::BYTE_W-1:0]  rx_byte,
    input  wire logic [nsf_pkg::OFF_W-1:0]   read_offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             sentence_done,
    output logic      [nsf_pkg::CNT_W-1:0]   pending_count,
    output logic      [nsf_pkg::HEAD_W-1:0]  head_length,
    output logic      [nsf_pkg::BYTE_W-1:0]  read_data
);

    import nsf_pkg::*;

    `include "nmea_sentence_framer_defines.svh"

    localparam int SW    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int LW    = $clog2(SLOT_BYTES);
    localparam int DEPTH = SLOTS * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (LW > OFF_W) ? LW : OFF_W;

    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [LW-1:0] FILL_LAST = LW'(SLOT_BYTES - 3);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] pending(input logic [SW-1:0] w,
                                              input logic [SW-1:0] r);
        logic [SW:0] d;
        if (w >= r)
        begin
            d = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            d = {1'b0, w} + (SW+1)'(SLOTS) - {1'b0, r};
        end
        return d[SW-1:0];
    endfunction

    // framing and ring state
    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic          cap_reg, cap_next;
    logic          cr_reg, cr_next;

    logic [LW-1:0] len_reg [SLOTS];

    // ram read stage and output register
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_done_reg;
    logic [CNT_W-1:0]    s1_cnt_reg;
    logic [HEAD_W-1:0]   s1_head_reg;
    logic                s1_hit_reg;
    logic                o_valid_reg, o_valid_next;
    logic                o_done_reg;
    logic [CNT_W-1:0]    o_cnt_reg;
    logic [HEAD_W-1:0]   o_head_reg;
    logic [BYTE_W-1:0]   o_data_reg;

    logic                in_acc;
    logic                s1_move;
    logic                done_c;
    logic                hit_c;
    logic                len_we;
    logic                mem_we;
    logic                rd_en;
    logic [SW-1:0]       pend_cur;
    logic [SW-1:0]       pend_after;
    logic [LW-1:0]       head_len;
    logic [CNT_W-1:0]    cnt_c;
    logic [HEAD_W-1:0]   head_c;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [BYTE_W-1:0]   ram_q;

    assign s1_move  = !o_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_acc   = in_valid && in_ready;
    assign pend_cur = pending(ws_reg, rs_reg);

    always_comb
    begin
        ws_next   = ws_reg;
        rs_next   = rs_reg;
        fill_next = fill_reg;
        cap_next  = cap_reg;
        cr_next   = cr_reg;
        done_c    = 1'b0;
        hit_c     = 1'b0;
        len_we    = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        if (in_acc)
        begin
            case (cmd_t'(cmd))
                CMD_RX:
                begin
                    if (rx_byte == CH_DOLLAR || rx_byte == CH_BANG)
                    begin
                        fill_next = '0;
                        cap_next  = (next_slot(ws_reg) != rs_reg);
                        cr_next   = 1'b0;
                    end
                    else if (rx_byte == CH_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    else if (rx_byte == CH_LF)
                    begin
                        if (cr_reg)
                        begin
                            cr_next = 1'b0;
                            if (cap_reg)
                            begin
                                cap_next = 1'b0;
                                len_we   = 1'b1;
                                ws_next  = next_slot(ws_reg);
                                done_c   = 1'b1;
                            end
                        end
                        else
                        begin
                            cap_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // a byte after a lone cr abandons the sentence
                        if (cr_reg)
                        begin
                            cr_next  = 1'b0;
                            cap_next = 1'b0;
                        end
                        if (cap_reg && !cr_reg)
                        begin
                            mem_we = 1'b1;
                            if (fill_reg == FILL_LAST)
                            begin
                                fill_next = '0;
                                cap_next  = 1'b0;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                    end
                end
                CMD_READ:
                begin
                    rd_en = 1'b1;
                    hit_c = (pend_cur != '0) &&
                            (CW'(read_offset) < CW'(len_reg[rs_reg]));
                end
                CMD_RELEASE:
                begin
                    if (pend_cur != '0)
                    begin
                        rs_next = next_slot(rs_reg);
                    end
                end
                CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // head length after this beat, taking a length written in the same beat
    always_comb
    begin
        pend_after = pending(ws_next, rs_next);
        if (len_we && rs_next == ws_reg)
        begin
            head_len = fill_reg;
        end
        else
        begin
            head_len = len_reg[rs_next];
        end
        cnt_c  = CNT_W'(pend_after);
        head_c = (pend_after != '0) ? HEAD_W'(head_len) : '0;
    end

    // the captured slot never equals the read slot while sentences wait,
    // so a read never meets a write to the same byte
    assign wr_addr = AW'(ws_reg) * AW'(SLOT_BYTES) + AW'(fill_reg);
    assign rd_addr = AW'(rs_reg) * AW'(SLOT_BYTES) + AW'(read_offset);

    nsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        s1_valid_next = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        o_valid_next  = s1_move ? s1_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg       <= '0;
            rs_reg       <= '0;
            fill_reg     <= '0;
            cap_reg      <= 1'b0;
            cr_reg       <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            ws_reg       <= ws_next;
            rs_reg       <= rs_next;
            fill_reg     <= fill_next;
            cap_reg      <= cap_next;
            cr_reg       <= cr_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_reg[ws_reg] <= fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_done_reg <= done_c;
            s1_cnt_reg  <= cnt_c;
            s1_head_reg <= head_c;
            s1_hit_reg  <= hit_c;
        end
        if (s1_move && s1_valid_reg)
        begin
            o_done_reg <= s1_done_reg;
            o_cnt_reg  <= s1_cnt_reg;
            o_head_reg <= s1_head_reg;
            o_data_reg <= s1_hit_reg ? ram_q : '0;
        end
    end

    assign out_valid     = o_valid_reg;
    assign sentence_done = o_done_reg;
    assign pending_count = o_cnt_reg;
    assign head_length   = o_head_reg;
    assign read_data     = o_data_reg;

    `NSF_ASSERT_IMP(a_fill_bound, cap_reg, fill_reg <= FILL_LAST, "fill position past slot limit")
    `NSF_ASSERT_IMP(a_cap_room, cap_reg, next_slot(ws_reg) != rs_reg, "capturing into a full ring")
    `NSF_ASSERT_NXT(a_done_adv, in_acc && done_c, ws_reg != $past(ws_reg), "write slot did not advance")
    `NSF_ASSERT_IMP(a_no_overrun, in_acc, !s1_valid_reg || s1_move, "read stage overwritten")

endmodule

`default_nettype wire
